// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame receiver.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge outside reset.
`define SFR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising clock edge, reset cycles included.
`define SFR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame receiver package
// Constants and beat types shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   localparam logic [7:0] PREAMBLE       = 8'hAA;
   localparam int         MAX_DATA_BYTES = 8;
   localparam int         KNOWN_ENTRIES  = 4;
   localparam int         CSR_REGS       = 4;
   localparam int         CSR_INDEX_W    = 4;
   localparam int         CSR_DATA_W     = 13;
   localparam int         FRAME_BYTES    = 8;
   localparam int         DATA_IDX_W     = 3;

   // known-message entry layout
   localparam int ENTRY_EN_BIT = 12;
   localparam int ENTRY_ID_LSB = 4;
   localparam int ENTRY_LEN_W  = 4;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } rx_beat_type;

   typedef struct packed {
      logic                   wr;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

endpackage

`default_nettype wire

// ===== hdl/sfr_known_table.sv =====
// ----------------------------------------------------------------------------
// Known-message table
// Holds the message table registers and matches an (id, length) pair.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_known_table import sfr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire csr_write_type csr_wr,
   input  wire logic [7:0]    id,
   input  wire logic [7:0]    len_byte,
   output logic               hit
);

   logic [CSR_DATA_W-1:0] known_ff [CSR_REGS];
   logic [CSR_DATA_W-1:0] known_in [CSR_REGS];
   logic                  len_ok;

   always_comb begin
      for (int i = 0; i < CSR_REGS; i++) begin
         known_in[i] = known_ff[i];
         if (csr_wr.wr && csr_wr.index == CSR_INDEX_W'(i)) begin
            known_in[i] = csr_wr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_REGS; i++) begin
            known_ff[i] <= '0;
         end
      end else begin
         known_ff <= known_in;
      end
   end

   // zero length or any length beyond the data store never matches
   assign len_ok = (len_byte != 8'd0) && (len_byte <= 8'(MAX_DATA_BYTES));

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < CSR_REGS; i++) begin
         if (i < KNOWN_ENTRIES && known_ff[i][ENTRY_EN_BIT]
             && known_ff[i][ENTRY_ID_LSB +: 8] == id
             && known_ff[i][ENTRY_LEN_W-1:0] == len_byte[ENTRY_LEN_W-1:0]) begin
            hit = 1'b1;
         end
      end
      hit = hit && len_ok;
   end

endmodule

`default_nettype wire

// ===== hdl/sfr_parser.sv =====
// ----------------------------------------------------------------------------
// Frame parser
// Byte-wise frame state machine, data store and registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_parser import sfr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rx_beat_type beat,
   input  wire logic        table_hit,
   output logic [7:0]       held_id,
   output logic             out_free,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_frame_id,
   output logic [3:0]       rsp_frame_length,
   output logic [63:0]      rsp_frame_data
);

   `include "assert_macros.svh"

   typedef enum logic [5:0] {
      PH_HUNT  = 6'b000001,
      PH_ID    = 6'b000010,
      PH_LEN   = 6'b000100,
      PH_DATA  = 6'b001000,
      PH_CK_HI = 6'b010000,
      PH_CK_LO = 6'b100000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [7:0]            id_ff, id_in;
   logic [3:0]            length_ff, length_in;
   logic [3:0]            left_ff, left_in;
   logic [15:0]           sum_ff, sum_in;
   logic [7:0]            ck_high_ff, ck_high_in;
   logic [7:0]            data_ff [FRAME_BYTES];
   logic [7:0]            data_in [FRAME_BYTES];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_id_ff, rsp_id_in;
   logic [3:0]            rsp_length_ff, rsp_length_in;
   logic [63:0]           rsp_data_ff, rsp_data_in;
   logic                  advance;
   logic                  emit;
   logic [7:0]            b;
   logic [15:0]           sum_plus;
   logic [DATA_IDX_W-1:0] data_idx;
   logic [63:0]           packed_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = beat.valid && out_free;
   assign b        = beat.rx_byte;
   assign sum_plus = sum_ff + {8'd0, b};
   assign data_idx = DATA_IDX_W'(length_ff - left_ff);
   assign held_id  = id_ff;

   always_comb begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         packed_data[i*8 +: 8] = data_ff[i];
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      id_in      = id_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      sum_in     = sum_ff;
      ck_high_in = ck_high_ff;
      data_in    = data_ff;
      emit       = 1'b0;
      if (advance) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (b == PREAMBLE) begin
                  for (int i = 0; i < FRAME_BYTES; i++) begin
                     data_in[i] = 8'd0;
                  end
                  id_in      = 8'd0;
                  length_in  = 4'd0;
                  left_in    = 4'd0;
                  ck_high_in = 8'd0;
                  sum_in     = {8'd0, b};
                  phase_in   = PH_ID;
               end
            end
            PH_ID: begin
               id_in    = b;
               sum_in   = sum_plus;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (table_hit) begin
                  length_in = b[3:0];
                  left_in   = b[3:0];
                  sum_in    = sum_plus;
                  phase_in  = PH_DATA;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               if (left_ff != 4'd0) begin
                  data_in[data_idx] = b;
                  sum_in            = sum_plus;
                  left_in           = left_ff - 4'd1;
                  if (left_ff == 4'd1) begin
                     phase_in = PH_CK_HI;
                  end
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_CK_HI: begin
               ck_high_in = b;
               phase_in   = PH_CK_LO;
            end
            PH_CK_LO: begin
               emit     = ({ck_high_ff, b} == sum_ff);
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      rsp_id_in     = rsp_id_ff;
      rsp_length_in = rsp_length_ff;
      rsp_data_in   = rsp_data_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_id_in     = id_ff;
         rsp_length_in = length_ff;
         rsp_data_in   = packed_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      length_ff     <= length_in;
      left_ff       <= left_in;
      sum_ff        <= sum_in;
      ck_high_ff    <= ck_high_in;
      data_ff       <= data_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_length_ff <= rsp_length_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_id     = rsp_id_ff;
   assign rsp_frame_length = rsp_length_ff;
   assign rsp_frame_data   = rsp_data_ff;

   `SFR_ASSERT(a_emit_from_ck_lo,
      $rose(rsp_valid_ff) |-> $past(phase_ff == PH_CK_LO), "result without checksum byte")
   `SFR_ASSERT(a_length_range,
      rsp_valid_ff |-> (rsp_length_ff != 4'd0 && rsp_length_ff <= 4'(MAX_DATA_BYTES)),
      "result length out of range")
   `SFR_ASSERT(a_left_bound,
      phase_ff == PH_DATA |-> (left_ff != 4'd0 && left_ff <= length_ff),
      "data byte count out of range")

endmodule

`default_nettype wire

// ===== hdl/serial_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver
// Preamble/length frame parser with a 16-bit additive checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and emits a decoded frame. Frame format:
// preamble 0xAA, message id, data length, 1 to 8 data bytes, checksum high,
// checksum low. The (id, length) pair must match an enabled entry of the
// known-message table (csr registers 0 to 3: bit 12 enable, bits 11:4 id,
// bits 3:0 length), otherwise the parser drops back to preamble hunting. The
// checksum is the modulo-65536 sum of preamble, id, length and data bytes; on
// a mismatch the frame is dropped without a result beat. Rate: one byte per
// clock unless the result register is stalled and full. A byte waits in the
// input register until the result register can take a beat, then the frame
// state machine parses it; a frame's result beat is registered when its last
// checksum byte is parsed. The single-entry result register sets the limit:
// while it is stalled and full, the input byte waits and req_stall rises. Table
// writes are taken in any cycle (csr_ready is always high) but must be made
// while the block is idle; indexes of 4 and up are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver import sfr_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // byte input channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_rx_byte,
   // frame result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_frame_id,
   output logic [3:0]                  rsp_frame_length,
   output logic [63:0]                 rsp_frame_data,
   // table write port
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   `include "assert_macros.svh"

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   rx_beat_type   beat;
   csr_write_type csr_wr;
   logic          out_free;
   logic          table_hit;
   logic [7:0]    held_id;
   logic          consume;

   // The table never backpressures a write.
   assign csr_ready    = 1'b1;
   assign csr_wr.wr    = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_wdata;

   // The parser consumes the held byte whenever the result register can take
   // a new beat; hold the byte otherwise.
   assign consume   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_byte_in = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else begin
         // drop the held byte once the parser has taken it
         in_valid_in = in_valid_ff && !consume;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   assign beat.valid   = in_valid_ff;
   assign beat.rx_byte = in_byte_ff;

   // Length byte is checked against the table with the id already held.
   sfr_known_table u_table (
      .clock    (clock),
      .reset    (reset),
      .csr_wr   (csr_wr),
      .id       (held_id),
      .len_byte (in_byte_ff),
      .hit      (table_hit)
   );

   sfr_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .beat             (beat),
      .table_hit        (table_hit),
      .held_id          (held_id),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_data   (rsp_frame_data)
   );

   `SFR_ASSERT_ALWAYS(a_stall_needs_byte,
      req_stall |-> in_valid_ff, "input stalled with empty input register")
   `SFR_ASSERT(a_held_byte_kept,
      (in_valid_ff && !consume) |=> (in_valid_ff && $stable(in_byte_ff)),
      "held byte lost before the parser took it")

endmodule

`default_nettype wire

// ===== bench/serial_frame_receiver_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame receiver checker
// Watches the byte, frame and table-write channels, predicts every frame from
// the accepted bytes and compares each frame beat field by field.
// ----------------------------------------------------------------------------
module serial_frame_receiver_checker import sfr_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [7:0]             req_rx_byte,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [7:0]             rsp_frame_id,
   input  wire logic [3:0]             rsp_frame_length,
   input  wire logic [63:0]            rsp_frame_data,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          mismatch_count,
   output int                          frames_outstanding
);

   typedef enum logic [5:0] {
      HUNT      = 6'b000001,
      GET_ID    = 6'b000010,
      GET_LEN   = 6'b000100,
      GET_DATA  = 6'b001000,
      GET_CK_HI = 6'b010000,
      GET_CK_LO = 6'b100000
   } parse_phase_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [3:0]  len;
      logic [63:0] data;
   } frame_beat_type;

   logic [CSR_DATA_W-1:0] msg_table [KNOWN_ENTRIES];
   parse_phase_type       phase_q  = HUNT;
   logic [7:0]            id_q;
   logic [3:0]            len_q;
   logic [3:0]            left_q;
   logic [7:0]            payload [FRAME_BYTES];
   logic [15:0]           sum_q;
   logic [7:0]            ck_hi_q;
   frame_beat_type        frames_due [$];
   int                    errs     = 0;

   function automatic logic pair_enabled(input logic [7:0] id, input logic [7:0] len);
      logic hit;
      hit = 1'b0;
      if (len != 0 && len <= MAX_DATA_BYTES) begin
         for (int i = 0; i < KNOWN_ENTRIES; i++) begin
            if (msg_table[i][ENTRY_EN_BIT] && msg_table[i][ENTRY_ID_LSB +: 8] == id &&
                msg_table[i][ENTRY_LEN_W-1:0] == len[3:0])
               hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // advance the parse state by one accepted byte
   task automatic take_byte(input logic [7:0] b);
      frame_beat_type f;
      logic [2:0]     slot;
      case (phase_q)
         HUNT: begin
            if (b == PREAMBLE) begin
               for (int i = 0; i < FRAME_BYTES; i++) payload[i] = 8'h00;
               id_q    = 8'h00;
               len_q   = 4'h0;
               left_q  = 4'h0;
               ck_hi_q = 8'h00;
               sum_q   = 16'(b);
               phase_q = GET_ID;
            end
         end
         GET_ID: begin
            id_q    = b;
            sum_q   = sum_q + 16'(b);
            phase_q = GET_LEN;
         end
         GET_LEN: begin
            if (pair_enabled(id_q, b)) begin
               len_q   = b[3:0];
               left_q  = b[3:0];
               sum_q   = sum_q + 16'(b);
               phase_q = GET_DATA;
            end else begin
               phase_q = HUNT;
            end
         end
         GET_DATA: begin
            if (left_q != 0) begin
               slot          = 3'(len_q - left_q);
               payload[slot] = b;
               sum_q         = sum_q + 16'(b);
               left_q        = left_q - 4'd1;
               if (left_q == 0) phase_q = GET_CK_HI;
            end else begin
               phase_q = HUNT;
            end
         end
         GET_CK_HI: begin
            ck_hi_q = b;
            phase_q = GET_CK_LO;
         end
         GET_CK_LO: begin
            if ({ck_hi_q, b} == sum_q) begin
               f.id   = id_q;
               f.len  = len_q;
               f.data = 64'h0;
               for (int i = 0; i < FRAME_BYTES; i++) f.data[8*i +: 8] = payload[i];
               frames_due.push_back(f);
            end
            phase_q = HUNT;
         end
         default: phase_q = HUNT;
      endcase
   endtask

   task automatic check_frame(input frame_beat_type got);
      frame_beat_type want;
      if (frames_due.size() == 0) begin
         errs++;
         $display("%0t: frame beat with none expected: id=%h len=%0d data=%h",
                  $time, got.id, got.len, got.data);
      end else begin
         want = frames_due.pop_front();
         if (got.id !== want.id) begin
            errs++;
            $display("%0t: frame_id expected %h, got %h", $time, want.id, got.id);
         end
         if (got.len !== want.len) begin
            errs++;
            $display("%0t: frame_length expected %0d, got %0d", $time, want.len, got.len);
         end
         if (got.data !== want.data) begin
            errs++;
            $display("%0t: frame_data expected %h, got %h", $time, want.data, got.data);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KNOWN_ENTRIES; i++) msg_table[i] = '0;
         for (int i = 0; i < FRAME_BYTES; i++) payload[i] = 8'h00;
         phase_q = HUNT;
         id_q    = 8'h00;
         len_q   = 4'h0;
         left_q  = 4'h0;
         sum_q   = 16'h0;
         ck_hi_q = 8'h00;
         frames_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_frame({rsp_frame_id, rsp_frame_length, rsp_frame_data});
         if (csr_valid && csr_ready && csr_index < CSR_REGS)
            msg_table[2'(csr_index)] = csr_wdata;
         if (req_valid && !req_stall)
            take_byte(req_rx_byte);
      end
      mismatch_count     <= errs;
      frames_outstanding <= frames_due.size();
   end

endmodule

// ===== bench/serial_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Drives directed and random byte streams through the frame receiver across
// several known-message tables, with random sender gaps and receiver stalls;
// the checker beside the block predicts and compares every frame beat.
// ----------------------------------------------------------------------------
module serial_frame_receiver_tb;
   import sfr_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int TOTAL_BYTES   = 600;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_stall   = 1'b0;
   logic                   csr_valid   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   wire                    req_stall;
   wire                    rsp_valid;
   wire [7:0]              rsp_frame_id;
   wire [3:0]              rsp_frame_length;
   wire [63:0]             rsp_frame_data;
   wire                    csr_ready;

   int mismatch_count;
   int frames_outstanding;

   // copy of the table as written, used to build frames the block will accept
   logic [CSR_DATA_W-1:0] written_entries [CSR_REGS];

   int burst_left = 0;
   bit gaps_on    = 1'b0;
   int bytes_sent = 0;
   int stall_tick = 0;

   always #HALF_PERIOD clock = ~clock;

   serial_frame_receiver u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_data   (rsp_frame_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   serial_frame_receiver_checker u_frame_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_frame_data     (rsp_frame_data),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .frames_outstanding (frames_outstanding)
   );

   // Receiver stall pattern: cycle through four modes picked by stall_tick[10:9] -
   // never stall, light random stall, a square wave from stall_tick[4], and
   // coin-flip stall. Free-running, so stalls land on every parse phase.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_tick[10:9])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= stall_tick[4];
         default: rsp_stall <= ($urandom_range(0, 1) == 1);
      endcase
   end

   function automatic logic [CSR_DATA_W-1:0] make_entry(input logic en, input logic [7:0] id,
                                                        input logic [3:0] len);
      logic [CSR_DATA_W-1:0] v;
      v                        = '0;
      v[ENTRY_EN_BIT]          = en;
      v[ENTRY_ID_LSB +: 8]     = id;
      v[ENTRY_LEN_W-1:0]       = len;
      return v;
   endfunction

   // Send one byte beat. The sender works in bursts; between bursts drop
   // valid for a random gap when gaps are enabled for this phase. Hold the
   // byte until the beat is taken.
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = gaps_on ? $urandom_range(0, 5) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Stop sending and wait until every predicted frame has come out, then
   // let the pipeline settle so that a dropped frame is fully parsed too.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < CSR_REGS) written_entries[2'(idx)] = value;
   endtask

   // Load all four entries plus one write to an index that has no register;
   // the block must ignore the stray write. Call only while the block is idle.
   task automatic load_table(input logic [CSR_DATA_W-1:0] e0, input logic [CSR_DATA_W-1:0] e1,
                             input logic [CSR_DATA_W-1:0] e2, input logic [CSR_DATA_W-1:0] e3,
                             input logic [CSR_DATA_W-1:0] stray);
      write_entry(CSR_INDEX_W'(0), e0);
      write_entry(CSR_INDEX_W'(1), e1);
      write_entry(CSR_INDEX_W'(2), e2);
      write_entry(CSR_INDEX_W'(3), e3);
      write_entry(CSR_INDEX_W'($urandom_range(CSR_REGS, 2**CSR_INDEX_W - 1)), stray);
      csr_valid <= 1'b0;
      @(posedge clock);
      gaps_on = ($urandom_range(0, 3) != 0);
   endtask

   // Send a complete frame of len data bytes; a nonzero ck_error corrupts
   // the checksum so the frame must be dropped.
   task automatic send_frame(input logic [7:0] id, input logic [3:0] len,
                             input logic [63:0] data, input logic [15:0] ck_error);
      logic [15:0] ck;
      ck = 16'(PREAMBLE) + 16'(id) + 16'(len);
      for (int i = 0; i < len; i++) ck = ck + 16'(data[8*i +: 8]);
      ck = ck ^ ck_error;
      push_byte(PREAMBLE);
      push_byte(id);
      push_byte(8'(len));
      for (int i = 0; i < len; i++) push_byte(data[8*i +: 8]);
      push_byte(ck[15:8]);
      push_byte(ck[7:0]);
   endtask

   // Random traffic: mostly well-formed frames for the current table, the
   // rest corrupted checksums, rejected headers, truncated frames, noise and
   // an occasional full drain.
   task automatic run_random(input int n_bytes);
      int          stop_at;
      int          kind;
      logic [1:0]  pick;
      logic [7:0]  id;
      logic [3:0]  len;
      logic [63:0] data;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         pick = 2'($urandom_range(0, CSR_REGS - 1));
         id   = written_entries[pick][ENTRY_ID_LSB +: 8];
         len  = written_entries[pick][ENTRY_LEN_W-1:0];
         data = {$urandom, $urandom};
         // pick an unusable entry? fall back to a random header
         if (!written_entries[pick][ENTRY_EN_BIT] || len == 0 || len > MAX_DATA_BYTES) begin
            id  = 8'($urandom);
            len = 4'($urandom_range(1, MAX_DATA_BYTES));
         end
         if (kind < 62) begin
            send_frame(id, len, data, 16'h0000);
         end else if (kind < 72) begin
            send_frame(id, len, data, 16'($urandom_range(1, 16'hFFFF)));
         end else if (kind < 78) begin
            push_byte(PREAMBLE);
            push_byte(id);
            push_byte(8'($urandom));
         end else if (kind < 86) begin
            push_byte(PREAMBLE);
            repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
         end else if (kind < 88) begin
            drain();
         end else begin
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      // hold reset, then release it
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: shortest frame at id 0, longest at id FF, an entry
      // whose length is above the maximum, one disabled entry, and a stray
      // write that would enable id 33 length 2 if it were not ignored.
      load_table(make_entry(1'b1, 8'h00, 4'd1), make_entry(1'b1, 8'hFF, 4'd8),
                 make_entry(1'b1, 8'h12, 4'd9), make_entry(1'b0, 8'hAB, 4'd3),
                 make_entry(1'b1, 8'h33, 4'd2));
      send_frame(8'h00, 4'd1, 64'h0, 16'h0000);
      send_frame(8'hFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
      // length zero is rejected
      push_byte(PREAMBLE); push_byte(8'h00); push_byte(8'h00);
      // length above the maximum is rejected even with a matching entry
      push_byte(PREAMBLE); push_byte(8'h12); push_byte(8'h09);
      // pair only written to a stray index: rejected
      push_byte(PREAMBLE); push_byte(8'h33); push_byte(8'h02);
      // rejected length byte equal to the preamble must not restart the hunt
      push_byte(PREAMBLE); push_byte(8'h00); push_byte(PREAMBLE);
      // checksum mismatch whose low byte equals the preamble: drop, no restart
      push_byte(PREAMBLE); push_byte(8'h00); push_byte(8'h01); push_byte(8'h55);
      push_byte(8'h00); push_byte(PREAMBLE);
      send_frame(8'h00, 4'd1, 64'h7E, 16'h0000);
      drain();

      // all-ones entries: enabled but length 15, so nothing may match
      load_table('1, '1, '1, '1, '1);
      run_random(60);
      drain();

      // all entries cleared
      load_table('0, '0, '0, '0, '0);
      run_random(60);
      drain();

      // extreme ids and lengths mixed with random valid entries
      load_table(make_entry(1'b1, 8'h00, 4'd1), make_entry(1'b1, 8'hFF, 4'd8),
                 make_entry(1'b1, 8'($urandom), 4'($urandom_range(1, MAX_DATA_BYTES))),
                 make_entry(1'b1, 8'($urandom), 4'($urandom_range(1, MAX_DATA_BYTES))),
                 13'($urandom));
      run_random(120);
      drain();

      // fully random entries, some disabled or with unusable lengths
      repeat (2) begin
         load_table(13'($urandom), make_entry(1'b1, 8'($urandom), 4'($urandom)),
                    make_entry(1'b1, 8'($urandom), 4'($urandom_range(1, MAX_DATA_BYTES))),
                    make_entry(1'($urandom_range(0, 1)), 8'($urandom),
                               4'($urandom_range(1, MAX_DATA_BYTES))),
                    13'($urandom));
         run_random(150);
         drain();
      end

      // final table: all usable, with a duplicated entry; run until enough
      // bytes have gone through
      begin
         logic [CSR_DATA_W-1:0] dup;
         dup = make_entry(1'b1, 8'($urandom), 4'($urandom_range(1, MAX_DATA_BYTES)));
         load_table(dup, make_entry(1'b1, 8'($urandom), 4'($urandom_range(1, MAX_DATA_BYTES))),
                    make_entry(1'b1, 8'($urandom), 4'($urandom_range(1, MAX_DATA_BYTES))),
                    dup, 13'($urandom));
         while (bytes_sent < TOTAL_BYTES) run_random(40);
      end
      drain();

      if (mismatch_count == 0 && frames_outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog: end the run if the handshakes ever hang
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sfr_pkg.sv
hdl/sfr_known_table.sv
hdl/sfr_parser.sv
hdl/serial_frame_receiver.sv
bench/serial_frame_receiver_checker.sv
bench/serial_frame_receiver_tb.sv
